// ===== rtl/ibd_pkg.sv =====
// Shared types, constants and lookup tables for the image block downscaler.
// Used by ibd_front, ibd_queue, ibd_back and image_block_downscaler_core.
`default_nettype none

package ibd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_FACTOR = 16;
   localparam int NCOLS      = MAX_WIDTH / 2;
   localparam int COL_W      = $clog2(NCOLS);
   localparam int CNT_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W    = 11;
   localparam int FACTOR_W   = 5;
   localparam int PIX_W      = 8;
   localparam int POS_W      = 4;
   localparam int HSUM_W     = 20;
   localparam int SUM_W      = 32;
   localparam int DATA_W     = 3 * PIX_W;
   localparam int CSR_ADDR_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Reciprocal shifts: block size divide and block-area divide
   localparam int BLK_RECIP_W     = 15;
   localparam int BLK_RECIP_SHIFT = 15;
   localparam int SQ_RECIP_W      = 23;
   localparam int SQ_RECIP_SHIFT  = 24;

   // 3x3 Gaussian kernel, row-major
   localparam logic [2:0] GAUSS_KERNEL [3][3] = '{
      '{3'd1, 3'd2, 3'd1},
      '{3'd2, 3'd4, 3'd2},
      '{3'd1, 3'd2, 3'd1}
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_SCALE_FACTOR = 2'd1,
      REG_COLOR_MODE   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [FACTOR_W-1:0] scale_factor;
      logic                color_mode;
   } cfg_type;

   // One column update handed from the front to the back
   typedef struct packed {
      logic [COL_W-1:0]             outcol;
      logic [2:0][HSUM_W-1:0]       hsum;     // index 0 red, 1 green, 2 blue
      logic                         first;    // first row of the block: overwrite
      logic                         emit;     // last row of the block: produce pixel
      logic                         row_end;
      logic [FACTOR_W-1:0]          root;     // divisor is root squared
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_MUL,
      ST_LOAD,
      ST_WAIT
   } back_state_type;

   // Effective block size from the factor register
   function automatic logic [FACTOR_W-1:0] blk_of(input logic [FACTOR_W-1:0] factor);
      logic [FACTOR_W-1:0] blk;
      if (factor[0]) begin
         blk = FACTOR_W'(3);
      end else if (factor < FACTOR_W'(2)) begin
         blk = FACTOR_W'(2);
      end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
         blk = FACTOR_W'(MAX_FACTOR) & ~FACTOR_W'(1);
      end else begin
         blk = factor;
      end
      return blk;
   endfunction

   // ceil(2^15 / blk): exact quotient for dividends up to MAX_WIDTH
   function automatic logic [BLK_RECIP_W-1:0] blk_recip(input logic [FACTOR_W-1:0] blk);
      logic [BLK_RECIP_W-1:0] r;
      unique case (blk)
         5'd2:    r = 15'd16384;
         5'd3:    r = 15'd10923;
         5'd4:    r = 15'd8192;
         5'd6:    r = 15'd5462;
         5'd8:    r = 15'd4096;
         5'd10:   r = 15'd3277;
         5'd12:   r = 15'd2731;
         5'd14:   r = 15'd2341;
         5'd16:   r = 15'd2048;
         default: r = '0;
      endcase
      return r;
   endfunction

   // ceil(2^24 / root^2): exact quotient for dividends below 2^16
   function automatic logic [SQ_RECIP_W-1:0] sq_recip(input logic [FACTOR_W-1:0] root);
      logic [SQ_RECIP_W-1:0] r;
      unique case (root)
         5'd2:    r = 23'd4194304;
         5'd4:    r = 23'd1048576;
         5'd6:    r = 23'd466034;
         5'd8:    r = 23'd262144;
         5'd10:   r = 23'd167773;
         5'd12:   r = 23'd116509;
         5'd14:   r = 23'd85599;
         5'd16:   r = 23'd65536;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ibd_front.sv =====
// Front end: pixel input register, raster position tracking and horizontal sums.
// Emits one column update per completed block row segment. Depends on ibd_pkg.
`default_nettype none

module ibd_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ibd_pkg::cfg_type           cfg,
   input  wire logic                       accept_en,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [ibd_pkg::DATA_W-1:0] in_data,
   input  wire logic                       in_first,
   input  wire logic                       cmd_ready,
   output logic                            cmd_valid,
   output ibd_pkg::cmd_type                cmd
);

   localparam int PROD_W  = ibd_pkg::CNT_W + ibd_pkg::BLK_RECIP_W;
   localparam int NPROD_W = ibd_pkg::WIDTH_W + ibd_pkg::BLK_RECIP_W;
   localparam int WP_W    = ibd_pkg::PIX_W + 3;

   logic                            pix_valid_ff, pix_valid_in;
   logic [ibd_pkg::DATA_W-1:0]      pix_data_ff;
   logic                            pix_first_ff;
   logic [ibd_pkg::CNT_W-1:0]       cc_ff, cc_in;
   logic [ibd_pkg::POS_W-1:0]       rib_ff, rib_in;
   logic [ibd_pkg::POS_W-1:0]       cib_ff, cib_in;
   logic [2:0][ibd_pkg::HSUM_W-1:0] hsum_ff, hsum_in;
   logic [ibd_pkg::WIDTH_W-1:0]     nblk_ff, nblk_in;

   logic [ibd_pkg::WIDTH_W-1:0]     width_sat;
   logic [ibd_pkg::FACTOR_W-1:0]    blk, blk_m1;
   logic [ibd_pkg::BLK_RECIP_W-1:0] recip;
   logic                            odd;
   logic [NPROD_W-1:0]              nblk_prod;
   logic                            take;
   logic [ibd_pkg::CNT_W-1:0]       cc;
   logic [ibd_pkg::POS_W-1:0]       rib, cib;
   logic [2:0][ibd_pkg::HSUM_W-1:0] hs, hs_add;
   logic [2:0][ibd_pkg::PIX_W-1:0]  px;
   logic [PROD_W-1:0]               q_prod;
   logic [ibd_pkg::CNT_W-1:0]       q;
   logic                            in_range, last_col, last_row, row_done;
   logic [1:0]                      kr, kc;
   logic [2:0]                      weight;
   logic [WP_W-1:0]                 wp;

   // Config-derived values
   always_comb begin
      if (cfg.image_width == '0) begin
         width_sat = ibd_pkg::WIDTH_W'(1);
      end else if (cfg.image_width > ibd_pkg::WIDTH_W'(ibd_pkg::MAX_WIDTH)) begin
         width_sat = ibd_pkg::WIDTH_W'(ibd_pkg::MAX_WIDTH);
      end else begin
         width_sat = cfg.image_width;
      end
      odd       = cfg.scale_factor[0];
      blk       = ibd_pkg::blk_of(cfg.scale_factor);
      blk_m1    = blk - ibd_pkg::FACTOR_W'(1);
      recip     = ibd_pkg::blk_recip(blk);
      nblk_prod = NPROD_W'(width_sat) * NPROD_W'(recip);
      nblk_in   = nblk_prod[NPROD_W-1 -: ibd_pkg::WIDTH_W];
   end

   assign take     = pix_valid_ff & cmd_ready;
   assign in_ready = accept_en & (~pix_valid_ff | take);

   always_comb begin
      pix_valid_in = pix_valid_ff;
      if (in_valid && in_ready) begin
         pix_valid_in = 1'b1;
      end else if (take) begin
         pix_valid_in = 1'b0;
      end
   end

   // Position and horizontal accumulation for the held pixel
   always_comb begin
      cc  = pix_first_ff ? '0 : cc_ff;
      rib = pix_first_ff ? '0 : rib_ff;
      cib = pix_first_ff ? '0 : cib_ff;
      hs  = pix_first_ff ? '0 : hsum_ff;

      px[0] = cfg.color_mode ? pix_data_ff[0 +: ibd_pkg::PIX_W] : '0;
      px[1] = cfg.color_mode ? pix_data_ff[ibd_pkg::PIX_W +: ibd_pkg::PIX_W] : '0;
      px[2] = pix_data_ff[2*ibd_pkg::PIX_W +: ibd_pkg::PIX_W];

      last_col = ibd_pkg::FACTOR_W'(cib) >= blk_m1;
      last_row = ibd_pkg::FACTOR_W'(rib) >= blk_m1;

      q_prod   = PROD_W'(cc) * PROD_W'(recip);
      q        = q_prod[ibd_pkg::BLK_RECIP_SHIFT +: ibd_pkg::CNT_W];
      in_range = ibd_pkg::WIDTH_W'(q) < nblk_ff;

      // Kernel positions beyond 2 use the last kernel row or column
      kr     = (rib > ibd_pkg::POS_W'(2)) ? 2'd2 : rib[1:0];
      kc     = (cib > ibd_pkg::POS_W'(2)) ? 2'd2 : cib[1:0];
      weight = odd ? ibd_pkg::GAUSS_KERNEL[kr][kc] : 3'd1;

      for (int c = 0; c < 3; c++) begin
         wp        = WP_W'(px[c]) * WP_W'(weight);
         hs_add[c] = hs[c] + ibd_pkg::HSUM_W'(wp);
      end

      cmd.outcol  = q[ibd_pkg::COL_W-1:0];
      cmd.hsum    = hs_add;
      cmd.first   = (rib == '0);
      cmd.emit    = last_row;
      cmd.row_end = (ibd_pkg::WIDTH_W'(q) + ibd_pkg::WIDTH_W'(1)) == nblk_ff;
      cmd.root    = odd ? ibd_pkg::FACTOR_W'(4) : blk;

      cmd_valid = take & in_range & last_col & (q < ibd_pkg::CNT_W'(ibd_pkg::NCOLS));

      hsum_in = hs;
      if (in_range) begin
         hsum_in = last_col ? '0 : hs_add;
      end

      row_done = (ibd_pkg::WIDTH_W'(cc) + ibd_pkg::WIDTH_W'(1)) >= width_sat;
      if (row_done) begin
         cc_in   = '0;
         cib_in  = '0;
         hsum_in = '0;
         rib_in  = last_row ? '0 : rib + ibd_pkg::POS_W'(1);
      end else begin
         cc_in  = cc + ibd_pkg::CNT_W'(1);
         cib_in = last_col ? '0 : cib + ibd_pkg::POS_W'(1);
         rib_in = rib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         cc_ff        <= '0;
         rib_ff       <= '0;
         cib_ff       <= '0;
         hsum_ff      <= '0;
         nblk_ff      <= '0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         nblk_ff      <= nblk_in;
         if (take) begin
            cc_ff   <= cc_in;
            rib_ff  <= rib_in;
            cib_ff  <= cib_in;
            hsum_ff <= hsum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pix_data_ff  <= in_data;
         pix_first_ff <= in_first;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ibd_queue.sv =====
// Short command queue between the front end and the back end.
// Holds ibd_pkg::cmd_type entries; depth from ibd_pkg::QUEUE_DEPTH.
`default_nettype none

module ibd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ibd_pkg::cmd_type push_cmd,
   output logic                  ready,
   input  wire logic             pop,
   output logic                  valid,
   output ibd_pkg::cmd_type      head
);

   ibd_pkg::cmd_type              entry_ff [ibd_pkg::QUEUE_DEPTH];
   logic [ibd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ibd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ibd_pkg::QPTR_W:0]      count_ff, count_in;

   assign ready = count_ff < (ibd_pkg::QPTR_W+1)'(ibd_pkg::QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (push && ready) ? wr_ptr_ff + ibd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = (pop && valid)  ? rd_ptr_ff + ibd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if ((push && ready) && !(pop && valid)) begin
         count_in = count_ff + (ibd_pkg::QPTR_W+1)'(1);
      end else if (!(push && ready) && (pop && valid)) begin
         count_in = count_ff - (ibd_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && ready) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Queue never overflows its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (ibd_pkg::QPTR_W+1)'(ibd_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // A push when full is dropped by the ready gate, so count cannot change on it
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (!ready && !pop) |=> $stable(count_ff))
      else $error("queue count changed while full and idle");

   // Pointers stay in step with the count
   a_ptr_sync: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers differ");

endmodule

`default_nettype wire

// ===== rtl/ibd_back.sv =====
// Back end: per-output-column sum memory, block-area divide and output register.
// Clears the column memory after reset. Depends on ibd_pkg.
`default_nettype none

module ibd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire ibd_pkg::cmd_type           q_head,
   output logic                            q_pop,
   output logic                            clearing,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [ibd_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int MPROD_W = 16 + ibd_pkg::SQ_RECIP_W;
   localparam int SQ_W    = 2 * ibd_pkg::FACTOR_W;

   logic [2:0][ibd_pkg::SUM_W-1:0] col_mem [ibd_pkg::NCOLS];
   logic [2:0][ibd_pkg::SUM_W-1:0] rd_data_ff;

   ibd_pkg::back_state_type         state_ff, state_in;
   logic [ibd_pkg::COL_W-1:0]       clr_ff, clr_in;
   ibd_pkg::cmd_type                cmd_ff, cmd_in;
   logic [2:0][ibd_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [2:0][ibd_pkg::PIX_W-1:0]  quo_ff, quo_in;
   logic [2:0]                      over_ff, over_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [2:0][ibd_pkg::PIX_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            mem_we;
   logic [ibd_pkg::COL_W-1:0]       mem_waddr;
   logic [2:0][ibd_pkg::SUM_W-1:0]  mem_wdata;
   logic [2:0][ibd_pkg::SUM_W-1:0]  acc;
   logic [SQ_W-1:0]                 sq;
   logic [ibd_pkg::SUM_W-1:0]       limit;
   logic [ibd_pkg::SQ_RECIP_W-1:0]  recip;
   logic [MPROD_W-1:0]              mprod;

   assign clearing   = (state_ff == ibd_pkg::ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc[c] = cmd_ff.first ? ibd_pkg::SUM_W'(cmd_ff.hsum[c])
                               : rd_data_ff[c] + ibd_pkg::SUM_W'(cmd_ff.hsum[c]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cmd_ff.outcol;
      mem_wdata    = acc;
      sq           = SQ_W'(cmd_ff.root) * SQ_W'(cmd_ff.root);
      limit        = ibd_pkg::SUM_W'({sq, 8'd0});
      recip        = ibd_pkg::sq_recip(cmd_ff.root);
      mprod        = '0;

      unique case (state_ff)
         ibd_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ibd_pkg::COL_W'(1);
            if (clr_ff == ibd_pkg::COL_W'(ibd_pkg::NCOLS - 1)) begin
               state_in = ibd_pkg::ST_IDLE;
            end
         end
         ibd_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = ibd_pkg::ST_ACC;
            end
         end
         ibd_pkg::ST_ACC: begin
            mem_we   = 1'b1;
            sum_in   = acc;
            state_in = cmd_ff.emit ? ibd_pkg::ST_MUL : ibd_pkg::ST_IDLE;
         end
         ibd_pkg::ST_MUL: begin
            // Sums at or above 256 times the divisor saturate; the rest fit 16 bits
            for (int c = 0; c < 3; c++) begin
               over_in[c] = sum_ff[c] >= limit;
               mprod      = MPROD_W'(sum_ff[c][15:0]) * MPROD_W'(recip);
               quo_in[c]  = mprod[ibd_pkg::SQ_RECIP_SHIFT +: ibd_pkg::PIX_W];
            end
            state_in = ibd_pkg::ST_LOAD;
         end
         ibd_pkg::ST_LOAD: begin
            for (int c = 0; c < 3; c++) begin
               rsp_data_in[c] = over_ff[c] ? {ibd_pkg::PIX_W{1'b1}} : quo_ff[c];
            end
            rsp_last_in  = cmd_ff.row_end;
            rsp_valid_in = 1'b1;
            state_in     = ibd_pkg::ST_WAIT;
         end
         ibd_pkg::ST_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ibd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ibd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      sum_ff      <= sum_in;
      quo_ff      <= quo_in;
      over_ff     <= over_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         col_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= col_mem[q_head.outcol];
   end

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ibd_pkg::ST_WAIT))
      else $error("result shown outside the wait state");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibd_pkg::ST_CLEAR) |-> !q_pop)
      else $error("command taken during memory clear");

   a_emit_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibd_pkg::ST_ACC && cmd_ff.emit) |=> (state_ff == ibd_pkg::ST_MUL))
      else $error("emitting update skipped the divide");

endmodule

`default_nettype wire

// ===== rtl/image_block_downscaler_core.sv =====
// Top level of the image block downscaler: config registers, front end, command
// queue and back end. Depends on ibd_pkg, ibd_front, ibd_queue and ibd_back.
`default_nettype none

// Raster-order RGB pixels enter on req_*, one per handshake, and each whole block
// of the image leaves as one pixel on rsp_*: an even factor F from 2 to 16 gives
// the truncated FxF box average, an odd factor gives a 3x3 block weighted 1-2-1
// and shifted down by 4. Columns and rows that do not fill a block produce nothing;
// rsp_tlast marks the last output pixel of an output row and req_tuser marks the
// first pixel of a frame. After reset all 512 entries of the column sum memory
// are cleared, during which req_tready stays low; config writes are taken at any time
// but should only be made while no item is in flight. Each completed block
// segment becomes a column update that the back end handles as a memory read and
// a read-modify-write, followed, when it produces a pixel, by the divide, the
// output load and a wait for rsp_tready. The block therefore takes a pixel per
// cycle while the command queue has room; on the last row of a block the back end
// can fall behind, and the four-entry command queue absorbs short bursts.

module image_block_downscaler_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Configuration write port
   input  wire logic                           csr_we,
   input  wire logic [ibd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [ibd_pkg::WIDTH_W-1:0]    csr_wdata,
   // Pixel input
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [ibd_pkg::DATA_W-1:0]     req_tdata,  // red, green, blue
   input  wire logic                           req_tuser,  // frame_start
   // Downscaled pixel output
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [ibd_pkg::DATA_W-1:0]          rsp_tdata,  // out_red, out_green, out_blue
   output logic                                rsp_tlast   // row_end
);

   ibd_pkg::cfg_type cfg_ff, cfg_in;
   logic             clearing;
   logic             cmd_valid, cmd_ready;
   ibd_pkg::cmd_type cmd;
   logic             q_valid, q_pop;
   ibd_pkg::cmd_type q_head;

   // Register writes; an index past the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (ibd_pkg::reg_index_type'(csr_addr))
            ibd_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            ibd_pkg::REG_SCALE_FACTOR: cfg_in.scale_factor = csr_wdata[ibd_pkg::FACTOR_W-1:0];
            ibd_pkg::REG_COLOR_MODE:   cfg_in.color_mode   = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= ibd_pkg::WIDTH_W'(640);
         cfg_ff.scale_factor <= ibd_pkg::FACTOR_W'(2);
         cfg_ff.color_mode   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: track raster position, build horizontal sums, hold off during clear
   ibd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept_en (~clearing),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_first  (req_tuser),
      .cmd_ready (cmd_ready),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // Decouple pixel intake from column memory updates
   ibd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_valid),
      .push_cmd (cmd),
      .ready    (cmd_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   // Back end: accumulate block rows per output column, divide, present result
   ibd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for image_block_downscaler_core: streams raster pixels in,
// predicts every downscaled pixel and compares each output item field by field.
// Depends on ibd_pkg and the RTL of image_block_downscaler_core.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 440;    // random pixels after the directed part
   localparam int QUIET_TAIL   = 200;    // last random pixels run without idling
   localparam int FLUSH_CYCLES = 40;     // drains a queue of four updates
   localparam int PHASE_CAP    = 600;    // keep one configuration from eating the run
   localparam int LIMIT_NS     = 5_000_000;

   // Tracks the block's sums and position and keeps the downscaled pixels that
   // the accepted input items are due to produce, oldest first.
   class downscale_tracker_type;
      typedef struct packed {
         logic [ibd_pkg::PIX_W-1:0] red;
         logic [ibd_pkg::PIX_W-1:0] green;
         logic [ibd_pkg::PIX_W-1:0] blue;
         logic                      row_end;
      } out_pixel_type;

      logic [ibd_pkg::WIDTH_W-1:0]  width_reg;
      logic [ibd_pkg::FACTOR_W-1:0] factor_reg;
      logic                         color_reg;

      int unsigned col_sum[ibd_pkg::NCOLS][3];   // block sums of whole block rows per column
      int unsigned row_sum[3];          // running sum of the current block within this row
      int unsigned col_pos;
      int unsigned row_in_blk;
      int unsigned col_in_blk;

      out_pixel_type expected_pixels[$];
      int failures;

      function new();
         width_reg  = 11'd640;
         factor_reg = 5'd2;
         color_reg  = 1'b1;
         foreach (col_sum[i, c]) col_sum[i][c] = 0;
         row_sum    = '{default: 0};
         col_pos    = 0;
         row_in_blk = 0;
         col_in_blk = 0;
         failures   = 0;
      endfunction

      // Odd factors all mean the 3x3 Gaussian; even ones clamp to 2..MAX_FACTOR.
      static function int unsigned block_size(logic [ibd_pkg::FACTOR_W-1:0] factor);
         if (factor[0]) return 3;
         if (factor < 2) return 2;
         if (factor > ibd_pkg::MAX_FACTOR) return ibd_pkg::MAX_FACTOR & ~1;
         return factor;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > ibd_pkg::MAX_WIDTH) return ibd_pkg::MAX_WIDTH;
         return width_reg;
      endfunction

      function void set_register(ibd_pkg::reg_index_type idx,
                                 logic [ibd_pkg::WIDTH_W-1:0] value);
         case (idx)
            ibd_pkg::REG_IMAGE_WIDTH:  width_reg  = value;
            ibd_pkg::REG_SCALE_FACTOR: factor_reg = value[ibd_pkg::FACTOR_W-1:0];
            ibd_pkg::REG_COLOR_MODE:   color_reg  = value[0];
            default: ;
         endcase
      endfunction

      function void take_pixel(logic [ibd_pkg::PIX_W-1:0] red, logic [ibd_pkg::PIX_W-1:0] green,
                               logic [ibd_pkg::PIX_W-1:0] blue, logic frame_start);
         int unsigned width, blk, nblocks, weight, outcol, v;
         int unsigned px[3];
         logic [ibd_pkg::PIX_W-1:0] ch[3];
         bit odd, last_col, last_row;
         out_pixel_type pix;
         width   = eff_width();
         blk     = block_size(factor_reg);
         odd     = factor_reg[0];
         nblocks = width / blk;

         if (frame_start) begin
            col_pos    = 0;
            row_in_blk = 0;
            col_in_blk = 0;
            row_sum    = '{default: 0};
         end

         px[0] = color_reg ? red : 8'd0;
         px[1] = color_reg ? green : 8'd0;
         px[2] = blue;

         last_col = col_in_blk >= blk - 1;
         last_row = row_in_blk >= blk - 1;

         if (col_pos < nblocks * blk) begin
            // Row and column 1 each double the weight (centre 4); all others, beyond 2 too, weigh 1
            if (odd) weight = (row_in_blk == 1 ? 2 : 1) * (col_in_blk == 1 ? 2 : 1);
            else weight = 1;
            for (int c = 0; c < 3; c++) row_sum[c] += px[c] * weight;

            if (last_col) begin
               outcol = col_pos / blk;
               if (outcol < ibd_pkg::NCOLS) begin
                  for (int c = 0; c < 3; c++) begin
                     if (row_in_blk == 0) col_sum[outcol][c] = row_sum[c];
                     else col_sum[outcol][c] += row_sum[c];
                  end
                  if (last_row) begin
                     for (int c = 0; c < 3; c++) begin
                        v     = odd ? (col_sum[outcol][c] >> 4) : col_sum[outcol][c] / (blk * blk);
                        ch[c] = (v > 255) ? 8'd255 : 8'(v);
                     end
                     pix.red     = ch[0];
                     pix.green   = ch[1];
                     pix.blue    = ch[2];
                     pix.row_end = (outcol + 1 == nblocks);
                     expected_pixels.push_back(pix);
                  end
               end
               row_sum = '{default: 0};
            end
         end

         if (col_pos + 1 >= width) begin
            col_pos    = 0;
            col_in_blk = 0;
            row_sum    = '{default: 0};
            row_in_blk = last_row ? 0 : row_in_blk + 1;
         end else begin
            col_pos++;
            col_in_blk = last_col ? 0 : col_in_blk + 1;
         end
      endfunction

      function void compare_field(string what, logic [ibd_pkg::PIX_W-1:0] want,
                                  logic [ibd_pkg::PIX_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            failures++;
         end
      endfunction

      function void check_out_pixel(logic [ibd_pkg::DATA_W-1:0] data, logic last);
         out_pixel_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: output pixel expected none actual %h last %b", $time, data, last);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("out_red", want.red, data[ibd_pkg::PIX_W-1:0]);
         compare_field("out_green", want.green, data[2*ibd_pkg::PIX_W-1:ibd_pkg::PIX_W]);
         compare_field("out_blue", want.blue, data[3*ibd_pkg::PIX_W-1:2*ibd_pkg::PIX_W]);
         compare_field("row_end", 8'(want.row_end), 8'(last));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [ibd_pkg::CSR_ADDR_W-1:0] csr_addr = ibd_pkg::REG_IMAGE_WIDTH;
   logic [ibd_pkg::WIDTH_W-1:0]    csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ibd_pkg::DATA_W-1:0]     req_tdata = '0;    // red, green, blue
   logic                           req_tuser = 1'b0;  // frame_start
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ibd_pkg::DATA_W-1:0]     rsp_tdata;         // out_red, out_green, out_blue
   logic                           rsp_tlast;         // row_end

   downscale_tracker_type tracker = new();

   int sent_items = 0;
   bit quiet = 1'b0;   // no idling on either side
   bit calm  = 1'b0;   // this configuration runs without source gaps
   int stall_left = 0;

   image_block_downscaler_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Sink side: hold tready low in random bursts, none started once quiet.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every accepted output item against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_out_pixel(rsp_tdata, rsp_tlast);
   end

   // Offer one pixel, maybe after a gap, and hold it until the block takes it.
   // Valid stays high across back-to-back items; it drops only for a gap.
   task automatic send_pixel(input logic [ibd_pkg::PIX_W-1:0] red,
                             input logic [ibd_pkg::PIX_W-1:0] green,
                             input logic [ibd_pkg::PIX_W-1:0] blue, input logic frame_start);
      int gap;
      gap = 0;
      if (!quiet && !calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_pixel(red, green, blue, frame_start);
      sent_items++;
   endtask

   // Drop valid, wait for every predicted pixel, then let the back end settle
   // on updates that produce nothing before touching the registers.
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   // Write enable stays high across consecutive writes; program_regs drops it.
   task automatic csr_write(input ibd_pkg::reg_index_type idx,
                            input logic [ibd_pkg::WIDTH_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   task automatic program_regs(input logic [ibd_pkg::WIDTH_W-1:0] width,
                               input logic [ibd_pkg::FACTOR_W-1:0] factor,
                               input logic color, input logic [2:0] mask);
      if (mask[0]) csr_write(ibd_pkg::REG_IMAGE_WIDTH, width);
      if (mask[1]) csr_write(ibd_pkg::REG_SCALE_FACTOR, ibd_pkg::WIDTH_W'(factor));
      if (mask[2]) csr_write(ibd_pkg::REG_COLOR_MODE, ibd_pkg::WIDTH_W'(color));
      csr_we <= 1'b0;
   endtask

   // Bias samples toward black and full scale so the sum extremes show up.
   function automatic logic [ibd_pkg::PIX_W-1:0] sample_value();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One random configuration followed by a stream sized to give a few block rows.
   task automatic random_phase(input int stop_at);
      logic [ibd_pkg::WIDTH_W-1:0]  width;
      logic [ibd_pkg::FACTOR_W-1:0] factor;
      logic [2:0]                   mask;
      int unsigned                  blk, rows, total;
      int                           room;
      bit                           fresh;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7: factor = 5'd2;
         8, 9, 10, 11:           factor = 5'($urandom_range(0, 15) * 2 + 1);   // any odd: Gaussian
         12, 13, 14:             factor = 5'd4;
         15, 16:                 factor = 5'($urandom_range(3, 4) * 2);
         17:                     factor = 5'($urandom_range(5, 8) * 2);
         18:                     factor = 5'($urandom_range(9, 15) * 2);       // clamps to 16
         default:                factor = 5'($urandom_range(0, 31));
      endcase
      blk = downscale_tracker_type::block_size(factor);
      case ($urandom_range(0, 15))
         0:       width = 11'd0;
         1:       width = 11'($urandom_range(1, blk - 1));   // narrower than one block
         default: begin
            if (blk <= 4) width = 11'(blk * $urandom_range(1, 8) + $urandom_range(0, blk - 1));
            else if (blk <= 8) width = 11'(blk * $urandom_range(1, 3) + $urandom_range(0, blk - 1));
            else width = 11'(blk + $urandom_range(0, 3));
         end
      endcase
      if (blk <= 4) rows = blk * $urandom_range(1, 3) + $urandom_range(0, blk - 1);
      else if (blk <= 8) rows = blk + $urandom_range(0, blk - 1);
      else rows = blk + $urandom_range(0, 1);

      // Now and then leave some registers as they were, or carry on mid-frame.
      mask = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
      program_regs(width, factor, 1'($urandom_range(0, 1)), mask);

      total = tracker.eff_width() * rows;
      if (total > PHASE_CAP) total = PHASE_CAP;
      room = stop_at - sent_items;
      if (total > unsigned'(room)) total = unsigned'(room);
      fresh = $urandom_range(0, 3) != 0;
      calm  = $urandom_range(0, 3) == 0;
      for (int n = 0; n < total; n++) begin
         quiet = sent_items + QUIET_TAIL >= stop_at;
         send_pixel(sample_value(), sample_value(), sample_value(),
                    (n == 0 && fresh) || $urandom_range(0, 149) == 0);
      end
      finish_burst();
   endtask

   initial begin
      int random_base;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Two-by-two box on a 4-wide frame: a full-scale block and a block mixing black with other pixels.
      program_regs(11'd4, 5'd2, 1'b1, 3'b111);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'h01, 8'h80, 8'hfe, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'h7f, 8'h55, 8'haa, 1'b0);
      finish_burst();

      // One 3x3 Gaussian block in grayscale: red and green must come out zero.
      program_regs(11'd3, 5'd3, 1'b0, 3'b111);
      for (int i = 0; i < 9; i++) send_pixel(8'(i * 31 + 7), 8'hff, 8'(255 - i * 13), i == 0);
      finish_burst();

      // Width zero acts as a single column; factor one still selects the Gaussian.
      program_regs(11'd0, 5'd1, 1'b1, 3'b011);
      for (int i = 0; i < 3; i++) send_pixel(8'd255, 8'd255, 8'd255, i == 0);
      finish_burst();

      // Widest frame: width above the maximum saturates, factor zero means two.
      // One full row writes every output column; the start of the next row
      // reads the first ones back.
      program_regs(11'h7ff, 5'd0, 1'b1, 3'b111);
      calm = 1'b0;
      for (int i = 0; i < ibd_pkg::MAX_WIDTH + 64; i++)
         send_pixel(sample_value(), sample_value(), sample_value(), i == 0);
      finish_burst();

      random_base = sent_items;
      while (sent_items < random_base + RANDOM_ITEMS) random_phase(random_base + RANDOM_ITEMS);

      finish_burst();
      if (tracker.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #LIMIT_NS;
      $display("tb: failure");
      $finish;
   end

endmodule
